// ===== rtl/led_twinkle_frame_engine_assert.svh =====
// Assertion shorthands used by the frame engine top module.
// Both expect clk and arst_n in scope.
`ifndef LED_TWINKLE_FRAME_ENGINE_ASSERT_SVH
`define LED_TWINKLE_FRAME_ENGINE_ASSERT_SVH

// same-cycle implication
`define LTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lte_pkg;

	localparam int MAX_PIXELS_DEF = 64;

	// field widths
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int COUNT_W = 7;
	localparam int LEVEL_W = 8;
	localparam int SPEED_W = 5;
	localparam int RAND_W = 32;
	localparam int PIX_W = 6;

	// operating limits
	localparam int COUNT_MIN = 2;
	localparam int SPEED_MIN = 1;
	localparam int SPEED_MAX = 30;
	localparam int BRT_FULL = 255;
	localparam int DIV_STEPS = RAND_W;

	// register reset values
	localparam logic ENABLE_RST = 1'b0;
	localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;
	localparam logic [LEVEL_W-1:0] LEVEL_RST = 8'd255;
	localparam logic [SPEED_W-1:0] SPEED_RST = 5'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE      = 3'd0,
		CFG_PIXEL_COUNT = 3'd1,
		CFG_RED         = 3'd2,
		CFG_GREEN       = 3'd3,
		CFG_BLUE        = 3'd4,
		CFG_INTENSITY   = 3'd5,
		CFG_FADE_SPEED  = 3'd6
	} cfg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch tick word and frame settings
		logic start;       // begin pixel pass and first modulo
		logic div2_start;  // begin star position modulo
		logic star_rd;     // read new star pixel
		logic star_wr;     // mark star pixel rising
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pass_done;
		logic div_done;
	} status_t;

	// video scaling: nonzero color at nonzero level never goes dark
	function automatic logic [LEVEL_W-1:0] vscale(input logic [LEVEL_W-1:0] c,
		input logic [LEVEL_W-1:0] s);
		logic [2*LEVEL_W-1:0] p;
		logic [LEVEL_W:0] r;
		p = (2*LEVEL_W)'(c) * (2*LEVEL_W)'(s);
		r = {1'b0, p[2*LEVEL_W-1:LEVEL_W]} + {{LEVEL_W{1'b0}}, (c != '0) && (s != '0)};
		return r[LEVEL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/led_twinkle_frame_engine.sv =====
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   random_word
//  out       source     out_valid / out_stall pixel_index, red_out, green_out,
//                                             blue_out, last_pixel
//  cfg       sink       cfg_we                cfg_index, cfg_wdata
//
//  An enabled tick runs the pixel pass, one pixel a cycle unless an output stall
//  holds it, alongside a 32-step remainder unit; then a second 32-step remainder
//  places the star. A disabled tick is taken and dropped without stalling input.
//  Output stalls hold the pixel pass; the block keeps its input stalled from an
//  enabled tick's accept until the star is placed. arst_n clears control, the
//  configuration and all pixel state (per-entry valid bits, so no clearing pass).
`timescale 1ns / 1ps
`default_nettype none

`include "led_twinkle_frame_engine_assert.svh"

module led_twinkle_frame_engine #(
	parameter int MAX_PIXELS = lte_pkg::MAX_PIXELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [lte_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lte_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// frame tick items
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [lte_pkg::RAND_W-1:0]      random_word,
	// pixel color items
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [lte_pkg::PIX_W-1:0]       pixel_index,
	output logic      [lte_pkg::LEVEL_W-1:0]     red_out,
	output logic      [lte_pkg::LEVEL_W-1:0]     green_out,
	output logic      [lte_pkg::LEVEL_W-1:0]     blue_out,
	output logic                                 last_pixel
);

	// configuration registers; the user must write them only between frames, the block does not enforce it
	logic                             enable_q;
	logic [lte_pkg::COUNT_W-1:0]      pixel_count_q;
	logic [lte_pkg::LEVEL_W-1:0]      red_level_q;
	logic [lte_pkg::LEVEL_W-1:0]      green_level_q;
	logic [lte_pkg::LEVEL_W-1:0]      blue_level_q;
	logic [lte_pkg::LEVEL_W-1:0]      intensity_q;
	logic [lte_pkg::SPEED_W-1:0]      fade_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= lte_pkg::ENABLE_RST;
			pixel_count_q <= lte_pkg::COUNT_RST;
			red_level_q   <= lte_pkg::LEVEL_RST;
			green_level_q <= lte_pkg::LEVEL_RST;
			blue_level_q  <= lte_pkg::LEVEL_RST;
			intensity_q   <= lte_pkg::LEVEL_RST;
			fade_speed_q  <= lte_pkg::SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lte_pkg::CFG_ENABLE:      enable_q      <= cfg_wdata[0];
				lte_pkg::CFG_PIXEL_COUNT: pixel_count_q <= cfg_wdata[lte_pkg::COUNT_W-1:0];
				lte_pkg::CFG_RED:         red_level_q   <= cfg_wdata[lte_pkg::LEVEL_W-1:0];
				lte_pkg::CFG_GREEN:       green_level_q <= cfg_wdata[lte_pkg::LEVEL_W-1:0];
				lte_pkg::CFG_BLUE:        blue_level_q  <= cfg_wdata[lte_pkg::LEVEL_W-1:0];
				lte_pkg::CFG_INTENSITY:   intensity_q   <= cfg_wdata[lte_pkg::LEVEL_W-1:0];
				lte_pkg::CFG_FADE_SPEED:  fade_speed_q  <= cfg_wdata[lte_pkg::SPEED_W-1:0];
				default: begin
					// unknown index: dropped
				end
			endcase
		end
	end

	lte_pkg::cmd_t    cmd;
	lte_pkg::status_t st;

	// sequencer: tick accept, pass / modulo / star placement
	lte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.enable  (enable_q),
		.st      (st),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	// pixel state memory, brightness math, remainder unit, output register
	lte_datapath #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.random_word(random_word),
		.pixel_count(pixel_count_q),
		.red_level  (red_level_q),
		.green_level(green_level_q),
		.blue_level (blue_level_q),
		.intensity  (intensity_q),
		.fade_speed (fade_speed_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.pixel_index(pixel_index),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.last_pixel (last_pixel)
	);

	// an idle block has nothing left in flight
	`LTE_ASSERT_IMP(a_idle_drained, !in_stall, st.pass_done && st.div_done, "idle with work pending")
	// a pending non-final pixel means the frame is still running
	`LTE_ASSERT_IMP(a_mid_frame_busy, out_valid && !last_pixel, in_stall, "frame item outside a frame")
	// star is placed only from a finished remainder
	`LTE_ASSERT_IMP(a_star_after_mod, cmd.star_wr, st.div_done, "star written during modulo")
	// a taken enabled tick blocks further ticks
	`LTE_ASSERT_NXT(a_load_busy, cmd.load, in_stall, "tick taken without going busy")

endmodule

`default_nettype wire

// ===== rtl/lte_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lte_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lte_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            enable,
	input  wire lte_pkg::status_t st,
	output logic                 in_stall,
	output lte_pkg::cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_RUN,
		S_MOD_START,
		S_MOD_WAIT,
		S_STAR_RD,
		S_STAR_WR
	} state_t;

	state_t state_q;
	logic   stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// disabled ticks are taken and dropped
					if (in_valid && enable) begin
						state_q <= S_START;
						stall_q <= 1'b1;
					end
				end
				S_START: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (st.pass_done && st.div_done) begin
						state_q <= S_MOD_START;
					end
				end
				S_MOD_START: begin
					state_q <= S_MOD_WAIT;
				end
				S_MOD_WAIT: begin
					if (st.div_done) begin
						state_q <= S_STAR_RD;
					end
				end
				S_STAR_RD: begin
					state_q <= S_STAR_WR;
				end
				S_STAR_WR: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall = stall_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid && enable;
		cmd.start      = (state_q == S_START);
		cmd.div2_start = (state_q == S_MOD_START);
		cmd.star_rd    = (state_q == S_STAR_RD);
		cmd.star_wr    = (state_q == S_STAR_WR);
	end

endmodule

`default_nettype wire

// ===== rtl/lte_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lte_datapath #(
	parameter int MAX_PIXELS = lte_pkg::MAX_PIXELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lte_pkg::cmd_t                  cmd,
	output lte_pkg::status_t                    st,
	input  wire logic [lte_pkg::RAND_W-1:0]     random_word,
	input  wire logic [lte_pkg::COUNT_W-1:0]    pixel_count,
	input  wire logic [lte_pkg::LEVEL_W-1:0]    red_level,
	input  wire logic [lte_pkg::LEVEL_W-1:0]    green_level,
	input  wire logic [lte_pkg::LEVEL_W-1:0]    blue_level,
	input  wire logic [lte_pkg::LEVEL_W-1:0]    intensity,
	input  wire logic [lte_pkg::SPEED_W-1:0]    fade_speed,
	input  wire logic                           out_stall,
	output logic                                out_valid,
	output logic      [lte_pkg::PIX_W-1:0]      pixel_index,
	output logic      [lte_pkg::LEVEL_W-1:0]    red_out,
	output logic      [lte_pkg::LEVEL_W-1:0]    green_out,
	output logic      [lte_pkg::LEVEL_W-1:0]    blue_out,
	output logic                                last_pixel
);

	localparam int IDX_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
	localparam int REM_W   = IDX_W + 1;
	localparam int LVL_W   = lte_pkg::LEVEL_W;
	localparam int SPD_W   = lte_pkg::SPEED_W;
	localparam int RND_W   = lte_pkg::RAND_W;
	localparam int CFGC_W  = lte_pkg::COUNT_W;
	localparam int PIX_W   = lte_pkg::PIX_W;
	localparam int WORD_W  = LVL_W + 1;               // {rising, brightness}
	localparam int PROD_W  = 2 * LVL_W + 1;
	localparam int DCNT_W  = $clog2(lte_pkg::DIV_STEPS);

	// ---------------- frame settings ----------------
	logic [RND_W-1:0]  rnd_q;
	logic [CNT_W-1:0]  n_q;
	logic [SPD_W-1:0]  step_q;
	logic [LVL_W-1:0]  base_r_q, base_g_q, base_b_q;
	logic [CFGC_W-1:0] cnt_clamped;
	logic [SPD_W-1:0]  spd_clamped;

	always_comb begin
		if (pixel_count < CFGC_W'(lte_pkg::COUNT_MIN)) begin
			cnt_clamped = CFGC_W'(lte_pkg::COUNT_MIN);
		end else if (pixel_count > CFGC_W'(MAX_PIXELS)) begin
			cnt_clamped = CFGC_W'(MAX_PIXELS);
		end else begin
			cnt_clamped = pixel_count;
		end
		if (fade_speed < SPD_W'(lte_pkg::SPEED_MIN)) begin
			spd_clamped = SPD_W'(lte_pkg::SPEED_MIN);
		end else if (fade_speed > SPD_W'(lte_pkg::SPEED_MAX)) begin
			spd_clamped = SPD_W'(lte_pkg::SPEED_MAX);
		end else begin
			spd_clamped = fade_speed;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rnd_q    <= random_word;
			n_q      <= cnt_clamped[CNT_W-1:0];
			step_q   <= spd_clamped + SPD_W'(1);
			base_r_q <= lte_pkg::vscale(red_level, intensity);
			base_g_q <= lte_pkg::vscale(green_level, intensity);
			base_b_q <= lte_pkg::vscale(blue_level, intensity);
		end
	end

	// ---------------- pixel pass ----------------
	logic [CNT_W-1:0]      issue_cnt_q;
	logic                  pass_q;
	logic                  s1_valid_q;
	logic [IDX_W-1:0]      idx_s1;
	logic                  last_s1;
	logic                  vld_s1;
	logic [MAX_PIXELS-1:0] vld_q;
	logic                  out_valid_q;
	logic                  adv, consume, issue;
	logic [IDX_W-1:0]      issue_addr;
	logic [IDX_W-1:0]      rem_q;
	logic [IDX_W-1:0]      star_q;

	logic                  ram_we, ram_re;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [WORD_W-1:0]     ram_wdata, ram_rdata;
	logic [WORD_W-1:0]     word_s1;

	assign adv        = !out_valid_q || !out_stall;
	assign consume    = s1_valid_q && adv;
	assign issue      = pass_q && (issue_cnt_q != n_q) && (!s1_valid_q || adv);
	assign issue_addr = issue_cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q      <= 1'b0;
			issue_cnt_q <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				pass_q      <= 1'b1;
				issue_cnt_q <= '0;
			end else begin
				if (issue) begin
					issue_cnt_q <= issue_cnt_q + CNT_W'(1);
				end
				if (pass_q && (issue_cnt_q == n_q) && !s1_valid_q) begin
					pass_q <= 1'b0;
				end
			end
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (consume) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= issue_addr;
			last_s1 <= (issue_cnt_q + CNT_W'(1)) == n_q;
		end
		if (ram_re) begin
			vld_s1 <= vld_q[ram_raddr];
		end
	end

	// entries never written read as dark and falling
	assign word_s1 = vld_s1 ? ram_rdata : '0;

	// brightness update
	logic [LVL_W-1:0] b_cur, v_new;
	logic [LVL_W:0]   up;
	logic             rise_new;
	logic [LVL_W:0]   f;
	logic [PROD_W-1:0] prod_r, prod_g, prod_b;

	always_comb begin
		b_cur = word_s1[LVL_W-1:0];
		up    = {1'b0, b_cur} + (LVL_W+1)'(step_q);
		if (word_s1[LVL_W]) begin
			if (up >= (LVL_W+1)'(lte_pkg::BRT_FULL)) begin
				v_new    = LVL_W'(lte_pkg::BRT_FULL);
				rise_new = 1'b0;
			end else begin
				v_new    = up[LVL_W-1:0];
				rise_new = 1'b1;
			end
		end else begin
			rise_new = 1'b0;
			if (b_cur > LVL_W'(step_q)) begin
				v_new = b_cur - LVL_W'(step_q);
			end else begin
				v_new = '0;
			end
		end
		f      = {1'b0, v_new} + (LVL_W+1)'(1);
		prod_r = PROD_W'(base_r_q) * PROD_W'(f);
		prod_g = PROD_W'(base_g_q) * PROD_W'(f);
		prod_b = PROD_W'(base_b_q) * PROD_W'(f);
	end

	// ---------------- state memory ----------------
	assign ram_re    = issue || cmd.star_rd;
	assign ram_raddr = cmd.star_rd ? rem_q : issue_addr;
	assign ram_we    = consume || cmd.star_wr;
	assign ram_waddr = cmd.star_wr ? rem_q : idx_s1;
	assign ram_wdata = cmd.star_wr ? {1'b1, word_s1[LVL_W-1:0]} : {rise_new, v_new};

	lte_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_PIXELS)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			star_q <= '0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.star_wr) begin
				star_q <= rem_q;
			end
		end
	end

	// ---------------- output register ----------------
	logic [PIX_W-1:0] pixel_index_q;
	logic [LVL_W-1:0] red_q, green_q, blue_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			pixel_index_q <= PIX_W'(idx_s1);
			red_q         <= prod_r[2*LVL_W-1:LVL_W];
			green_q       <= prod_g[2*LVL_W-1:LVL_W];
			blue_q        <= prod_b[2*LVL_W-1:LVL_W];
			last_q        <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign last_pixel  = last_q;

	// ---------------- remainder unit, one bit a cycle ----------------
	logic               div_busy_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [RND_W-1:0]   dvd_q;
	logic [REM_W-1:0]   dvs_q;
	logic [REM_W-1:0]   sh, diff, star_sum;
	logic               ge;

	assign sh       = {rem_q, dvd_q[RND_W-1]};
	assign ge       = sh >= dvs_q;
	assign diff     = sh - dvs_q;
	// offset is remainder + 1
	assign star_sum = REM_W'(star_q) + REM_W'(rem_q) + REM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.start || cmd.div2_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
			if (div_cnt_q == DCNT_W'(lte_pkg::DIV_STEPS - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= rnd_q;
			dvs_q <= REM_W'(n_q) - REM_W'(1);
			rem_q <= '0;
		end else if (cmd.div2_start) begin
			dvd_q <= RND_W'(star_sum);
			dvs_q <= REM_W'(n_q);
			rem_q <= '0;
		end else if (div_busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= ge ? diff[IDX_W-1:0] : sh[IDX_W-1:0];
		end
	end

	always_comb begin
		st           = '0;
		st.pass_done = !pass_q;
		st.div_done  = !div_busy_q;
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lte_pkg::*;

	localparam int MAX_PIX = MAX_PIXELS_DEF;
	// Write that lands past the last register and must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam int FRAME_TARGET = 310;  // frame ticks to send
	// Settle time after the last color, long enough for star placement to finish.
	localparam int SETTLE_CYCLES = 160;
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int STALL_LIMIT = 3000;  // cycles with no item moving on either side
	localparam int PRINT_CAP = 25;
	localparam int HOLD_PHASE = 1;      // random phase that gets the hold-off
	localparam int CALM_PHASE = 2;      // random phase with no idling on either side

	typedef struct packed {
		logic [PIX_W-1:0]   pix;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic               ends_frame;
	} pixel_color_t;

	// ---------------------------------------------------------------- DUT I/O
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [RAND_W-1:0]     random_word = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_W-1:0]      pixel_index;
	logic [LEVEL_W-1:0]    red_out;
	logic [LEVEL_W-1:0]    green_out;
	logic [LEVEL_W-1:0]    blue_out;
	logic                  last_pixel;

	led_twinkle_frame_engine u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.last_pixel  (last_pixel)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------- shared tb state
	logic [RAND_W-1:0] tick_words[$];       // frame ticks waiting for the driver
	pixel_color_t      pending_colors[$];   // predicted pixel colors, oldest first

	// Shadow of the register file, updated as each write is issued.
	logic               sh_enable = ENABLE_RST;
	logic [COUNT_W-1:0] sh_count = COUNT_RST;
	logic [LEVEL_W-1:0] sh_red = LEVEL_RST;
	logic [LEVEL_W-1:0] sh_green = LEVEL_RST;
	logic [LEVEL_W-1:0] sh_blue = LEVEL_RST;
	logic [LEVEL_W-1:0] sh_level = LEVEL_RST;
	logic [SPEED_W-1:0] sh_speed = SPEED_RST;

	// Predicted pixel state.
	logic [LEVEL_W-1:0] glow [MAX_PIX];
	logic               climbing [MAX_PIX];
	logic [PIX_W-1:0]   star_pix;

	logic send_calm = 1'b0;
	logic recv_calm = 1'b0;
	logic hold_req = 1'b0;

	int mismatches = 0;
	int colors_checked = 0;
	int frames_sent = 0;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		// Count every failure; print only the first few.
		if (mismatches < PRINT_CAP)
			$display("mismatch on %s at color %0d: got %0d, want %0d",
				what, colors_checked, got, want);
		mismatches++;
	endtask

	// Video-style dimming: a lit channel at a nonzero level never drops to zero.
	function automatic int unsigned dim_by_level(input logic [LEVEL_W-1:0] c,
		input logic [LEVEL_W-1:0] s);
		return ((int'(c) * int'(s)) >> 8) + ((c != 0 && s != 0) ? 1 : 0);
	endfunction

	// One frame tick, if enabled: fade or brighten each pixel in use, queue its color,
	// then move the star and set it rising.
	task automatic advance_frame(input logic [RAND_W-1:0] word);
		int unsigned used, stp, lvl, base_r, base_g, base_b, offs, i;
		pixel_color_t c;
		if (sh_enable) begin
			used = sh_count;
			if (used < COUNT_MIN) used = COUNT_MIN;
			if (used > MAX_PIX) used = MAX_PIX;
			stp = sh_speed;
			if (stp < SPEED_MIN) stp = SPEED_MIN;
			if (stp > SPEED_MAX) stp = SPEED_MAX;
			stp = stp + 1;
			base_r = dim_by_level(sh_red, sh_level);
			base_g = dim_by_level(sh_green, sh_level);
			base_b = dim_by_level(sh_blue, sh_level);
			for (i = 0; i < used; i++) begin
				lvl = glow[i];
				if (climbing[i]) begin
					lvl = lvl + stp;
					if (lvl >= BRT_FULL) begin
						lvl = BRT_FULL;
						climbing[i] = 1'b0;
					end
				end else begin
					lvl = (lvl > stp) ? lvl - stp : 0;
				end
				glow[i] = lvl[7:0];
				c.pix = i[PIX_W-1:0];
				c.red = 8'((base_r * (lvl + 1)) >> 8);
				c.green = 8'((base_g * (lvl + 1)) >> 8);
				c.blue = 8'((base_b * (lvl + 1)) >> 8);
				c.ends_frame = (i + 1 == used);
				pending_colors.push_back(c);
			end
			// a star left past a lowered count still wraps back into range
			offs = 1 + word % (used - 1);
			star_pix = 6'((star_pix + offs) % used);
			climbing[star_pix] = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------- driver
	// Frame ticks go out in queue order; a stalled tick is held unchanged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			random_word <= '0;
		end else if (!in_valid || !in_stall) begin
			if (tick_words.size() != 0 && (send_calm || $urandom_range(99) >= 23)) begin
				in_valid <= 1'b1;
				random_word <= tick_words.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------------- receiver
	// Random stalls, plus one long hold-off so the pixel pass backs up and
	// the block has to stall its tick input while the driver keeps offering.
	int  hold_left = 0;
	logic hold_taken = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			out_stall <= !recv_calm && ($urandom_range(99) < 23);
		end
	end

	// --------------------------------------------------------------- monitor
	// Accepted ticks feed the predictor; accepted colors are checked against
	// the oldest prediction. Also the watchdog: too long with nothing moving
	// on either channel ends the run.
	int quiet_cycles = 0;

	always @(posedge clk) begin : mon
		pixel_color_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				advance_frame(random_word);
			if (out_valid && !out_stall) begin
				if (pending_colors.size() == 0) begin
					report_mismatch("unexpected color item", pixel_index, 0);
				end else begin
					want = pending_colors.pop_front();
					if (pixel_index !== want.pix)
						report_mismatch("pixel_index", pixel_index, want.pix);
					if (red_out !== want.red)
						report_mismatch("red_out", red_out, want.red);
					if (green_out !== want.green)
						report_mismatch("green_out", green_out, want.green);
					if (blue_out !== want.blue)
						report_mismatch("blue_out", blue_out, want.blue);
					if (last_pixel !== want.ends_frame)
						report_mismatch("last_pixel", last_pixel, want.ends_frame);
				end
				colors_checked++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// -------------------------------------------------------------- stimulus
	// Register writes only while the block is idle; the shadow copy follows.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_ENABLE:      sh_enable = val[0];
			CFG_PIXEL_COUNT: sh_count = val[COUNT_W-1:0];
			CFG_RED:         sh_red = val;
			CFG_GREEN:       sh_green = val;
			CFG_BLUE:        sh_blue = val;
			CFG_INTENSITY:   sh_level = val;
			CFG_FADE_SPEED:  sh_speed = val[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic push_tick(input logic [RAND_W-1:0] w);
		tick_words.push_back(w);
		frames_sent++;
	endtask

	// Wait for every tick to go in and every color to come out, then let
	// the star placement (or a disabled tick) finish before touching registers.
	task automatic drain();
		do @(negedge clk);
		while (tick_words.size() != 0 || in_valid || pending_colors.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly short strips, sometimes full length, sometimes out of range.
	function automatic logic [CFG_DATA_W-1:0] pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'($urandom_range(12, 2));
		if (r < 80)
			return 8'($urandom_range(63, 13));
		if (r < 90)
			return 8'(MAX_PIX);
		return 8'($urandom);
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 2)
			return 8'h00;
		if (r < 4)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [RAND_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return RAND_W'($urandom_range(3));
		if (r == 1)
			return '1 - RAND_W'($urandom_range(3));
		return $urandom;
	endfunction

	initial begin
		int k;
		int phase_no;
		int unsigned r;
		for (k = 0; k < MAX_PIX; k++) begin
			glow[k] = '0;
			climbing[k] = 1'b0;
		end
		star_pix = '0;
		phase_no = 0;

		// release reset away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// disabled out of reset: ticks vanish
		push_tick('0);
		push_tick('1);
		drain();

		// every register; count 127 clamps to 64, speed 31 clamps to 30,
		// plus a write past the register list
		write_reg(CFG_ENABLE, 8'h01);
		write_reg(CFG_PIXEL_COUNT, 8'hFF);
		write_reg(CFG_RED, 8'hFF);
		write_reg(CFG_GREEN, 8'h00);
		write_reg(CFG_BLUE, 8'h80);
		write_reg(CFG_INTENSITY, 8'hFF);
		write_reg(CFG_FADE_SPEED, 8'hFF);
		write_reg(CFG_SPARE, 8'h55);
		end_writes();
		push_tick(32'h0000_0000);
		push_tick(32'hFFFF_FFFF);
		push_tick(32'd62);
		drain();

		// count 1 used as 2, speed 0 used as 1, intensity off; star starts
		// past the count and then bounces between two pixels, landing on
		// one that is still rising
		write_reg(CFG_PIXEL_COUNT, 8'd1);
		write_reg(CFG_FADE_SPEED, 8'h00);
		write_reg(CFG_INTENSITY, 8'h00);
		write_reg(CFG_RED, 8'h00);
		write_reg(CFG_GREEN, 8'hFF);
		end_writes();
		repeat (6) push_tick($urandom);
		drain();

		write_reg(CFG_PIXEL_COUNT, 8'd0);
		write_reg(CFG_FADE_SPEED, 8'd30);
		write_reg(CFG_INTENSITY, 8'hFF);
		end_writes();
		push_tick('1);
		push_tick($urandom);
		drain();

		// count 65 used as 64: pixels skipped above show their kept state
		write_reg(CFG_PIXEL_COUNT, 8'd65);
		write_reg(CFG_RED, 8'd1);
		write_reg(CFG_GREEN, 8'd1);
		write_reg(CFG_BLUE, 8'hFF);
		write_reg(CFG_INTENSITY, 8'd1);
		end_writes();
		repeat (3) push_tick($urandom);
		drain();

		// disable with the upper bits set; state must survive
		write_reg(CFG_ENABLE, 8'hFE);
		end_writes();
		repeat (3) push_tick($urandom);
		drain();
		write_reg(CFG_ENABLE, 8'h01);
		write_reg(CFG_PIXEL_COUNT, 8'd64);
		end_writes();
		repeat (2) push_tick($urandom);
		drain();

		// random phases: fresh settings each time, mostly enabled
		while (frames_sent < FRAME_TARGET) begin
			r = $urandom_range(99);
			write_reg(CFG_ENABLE, {7'($urandom), r >= 8});
			write_reg(CFG_PIXEL_COUNT, pick_count());
			write_reg(CFG_RED, pick_level());
			write_reg(CFG_GREEN, pick_level());
			write_reg(CFG_BLUE, pick_level());
			write_reg(CFG_INTENSITY, pick_level());
			write_reg(CFG_FADE_SPEED, 8'($urandom));
			if ($urandom_range(9) == 0)
				write_reg(CFG_SPARE, 8'($urandom));
			if (phase_no == HOLD_PHASE) begin
				write_reg(CFG_ENABLE, 8'h01);
				write_reg(CFG_PIXEL_COUNT, 8'(MAX_PIX));
			end
			end_writes();
			if (phase_no == CALM_PHASE) begin
				send_calm <= 1'b1;
				recv_calm <= 1'b1;
			end
			repeat ($urandom_range(16, 4)) push_tick(pick_word());
			if (phase_no == HOLD_PHASE)
				hold_req <= 1'b1;
			drain();
			send_calm <= 1'b0;
			recv_calm <= 1'b0;
			phase_no++;
		end

		if (pending_colors.size() != 0)
			report_mismatch("colors never delivered", pending_colors.size(), 0);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
